// ===== rtl/core/acpd_pkg.sv =====
// shared types, codes and helper functions for the access-control packet deframer
// no dependencies; used by every module of the block
package acpd_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIPH_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_SEQ    = 2'd2;

    // request codes on the input channel
    localparam logic [1:0] REQ_RX_BYTE    = 2'd0;
    localparam logic [1:0] REQ_TX_HEADER  = 2'd1;
    localparam logic [1:0] REQ_LINK_RESET = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_STATUS   = 2'd1;
    localparam logic [1:0] KIND_SEQUENCE = 2'd2;

    // frame status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MARK     = 3'd1;
    localparam logic [2:0] ST_LENGTH   = 3'd2;
    localparam logic [2:0] ST_REPLY    = 3'd3;
    localparam logic [2:0] ST_ADDRESS  = 3'd4;
    localparam logic [2:0] ST_SEQUENCE = 3'd5;
    localparam logic [2:0] ST_CRC      = 3'd6;
    localparam logic [2:0] ST_CHECKSUM = 3'd7;

    localparam logic [7:0]  MARK_BYTE   = 8'hFF;
    localparam logic [7:0]  START_BYTE  = 8'h53;
    localparam logic [15:0] CRC_SEED    = 16'h1D0F;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [2:0]  SEQ_RESET   = 3'b111;
    localparam int unsigned CTRL_CRC_BIT = 2;
    localparam int unsigned ADDR_REPLY_BIT = 7;
    localparam logic [15:0] HDR_LEN      = 16'd6;
    localparam logic [15:0] MIN_LAST_CRC = 16'd7;
    localparam logic [15:0] MIN_LAST_SUM = 16'd6;
    localparam logic [15:0] IDX_ADDRESS  = 16'd2;
    localparam logic [15:0] IDX_LEN_LO   = 16'd3;
    localparam logic [15:0] IDX_LEN_HI   = 16'd4;
    localparam logic [15:0] IDX_CONTROL  = 16'd5;

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_HEADER,
        OP_LINK_RESET
    } t_op;

    // classified item passed from front to back
    typedef struct packed {
        t_op        op;
        logic [7:0] rx_byte;
        logic       frame_end;
        logic       is_mark;
        logic       is_start;
    } t_cmd;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // signed three-bit step, wraps from 3 back to 1
    function automatic logic [2:0] seq_advance(input logic [2:0] s);
        logic [2:0] r;
        if (s == 3'd3) begin
            r = 3'd1;
        end else begin
            r = s + 3'd1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/acpd_front.sv =====
// front end: accepts input transfers and classifies them into commands
// depends on acpd_pkg
module acpd_front (
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_req_type,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_frame_end,
    input  logic             i_queue_full,
    output logic             o_push,
    output acpd_pkg::t_cmd   o_cmd
);

    logic accept;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.rx_byte   = i_rx_byte;
        o_cmd.frame_end = i_frame_end;
        o_cmd.is_mark   = (i_rx_byte == acpd_pkg::MARK_BYTE);
        o_cmd.is_start  = (i_rx_byte == acpd_pkg::START_BYTE);
        o_cmd.op        = acpd_pkg::OP_BYTE;
        o_push          = 1'b0;
        case (i_req_type)
            acpd_pkg::REQ_RX_BYTE: begin
                o_cmd.op = acpd_pkg::OP_BYTE;
                o_push   = accept;
            end
            acpd_pkg::REQ_TX_HEADER: begin
                o_cmd.op = acpd_pkg::OP_HEADER;
                o_push   = accept;
            end
            acpd_pkg::REQ_LINK_RESET: begin
                o_cmd.op = acpd_pkg::OP_LINK_RESET;
                o_push   = accept;
            end
            // unused request: taken and dropped
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/acpd_queue.sv =====
// short command queue between front and back
// depends on acpd_pkg
module acpd_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  acpd_pkg::t_cmd   i_cmd,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output acpd_pkg::t_cmd   o_cmd
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    acpd_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/core/acpd_back.sv =====
// back end: frame state, crc/checksum, verdict and the registered result stage
// depends on acpd_pkg
module acpd_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [acpd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [acpd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_cmd_valid,
    input  acpd_pkg::t_cmd                 i_cmd,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_result_kind,
    output logic [7:0]                     o_payload_byte,
    output logic [2:0]                     o_frame_status,
    output logic [1:0]                     o_sequence_out,
    output logic                           o_is_last
);

    // configuration
    logic [6:0] r_own_address;
    logic       r_periph;
    logic       r_skip_seq;

    // frame and link state
    logic [15:0] r_idx, n_idx;
    logic [15:0] r_len, n_len;
    logic [7:0]  r_addr, n_addr;
    logic [7:0]  r_ctrl, n_ctrl;
    logic        r_mark_ok, n_mark_ok;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_prev, n_prev;
    logic [2:0]  r_seq, n_seq;

    // result stage
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_payload;
    logic [2:0]  r_status;
    logic [1:0]  r_seq_out;

    logic        res_valid;
    logic [1:0]  res_kind;
    logic [7:0]  res_payload;
    logic [2:0]  res_status;
    logic [1:0]  res_seq;
    logic        clear_frame;

    logic [2:0]  seq_adv;
    logic [15:0] crc_next;
    logic [16:0] idx_wide, len_wide;
    logic        crc_mode;

    assign o_pop    = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign seq_adv  = acpd_pkg::seq_advance(r_seq);
    assign crc_next = acpd_pkg::crc_feed(r_crc, i_cmd.rx_byte);
    assign idx_wide = {1'b0, r_idx};
    assign len_wide = {1'b0, r_len};
    assign crc_mode = r_ctrl[acpd_pkg::CTRL_CRC_BIT];

    always_comb begin
        logic [15:0] min_last;
        logic [2:0]  seq_now;
        logic [16:0] top;

        n_idx       = r_idx;
        n_len       = r_len;
        n_addr      = r_addr;
        n_ctrl      = r_ctrl;
        n_mark_ok   = r_mark_ok;
        n_crc       = r_crc;
        n_sum       = r_sum;
        n_prev      = r_prev;
        n_seq       = r_seq;
        res_valid   = 1'b0;
        res_kind    = acpd_pkg::KIND_PAYLOAD;
        res_payload = 8'h00;
        res_status  = acpd_pkg::ST_OK;
        res_seq     = 2'd0;
        clear_frame = 1'b0;
        min_last    = crc_mode ? acpd_pkg::MIN_LAST_CRC : acpd_pkg::MIN_LAST_SUM;
        seq_now     = r_periph ? seq_adv : r_seq;
        top         = crc_mode ? 17'd2 : 17'd1;

        case (i_cmd.op)
            acpd_pkg::OP_HEADER: begin
                if (!r_periph) begin
                    n_seq = seq_adv;
                end
                res_valid = 1'b1;
                res_kind  = acpd_pkg::KIND_SEQUENCE;
                res_seq   = r_periph ? r_seq[1:0] : seq_adv[1:0];
            end
            acpd_pkg::OP_LINK_RESET: begin
                n_seq       = acpd_pkg::SEQ_RESET;
                clear_frame = 1'b1;
            end
            acpd_pkg::OP_BYTE: begin
                if ((r_idx == 16'd0 && !i_cmd.is_mark) || (r_idx == 16'd1 && !i_cmd.is_start)) begin
                    n_mark_ok = 1'b0;
                end
                if (i_cmd.frame_end) begin
                    res_valid   = 1'b1;
                    res_kind    = acpd_pkg::KIND_STATUS;
                    clear_frame = 1'b1;
                    // checks in status-code order, first failure wins
                    if (r_idx == 16'd0 || !n_mark_ok) begin
                        res_status = acpd_pkg::ST_MARK;
                    end else if (r_idx < min_last || r_idx != r_len) begin
                        res_status = acpd_pkg::ST_LENGTH;
                    end else if (!r_periph && !r_addr[acpd_pkg::ADDR_REPLY_BIT]) begin
                        res_status = acpd_pkg::ST_REPLY;
                    end else if (r_addr[6:0] != r_own_address) begin
                        res_status = acpd_pkg::ST_ADDRESS;
                    end else begin
                        if (r_periph) begin
                            n_seq = seq_adv;
                        end
                        if (seq_now[1:0] != r_ctrl[1:0] && !r_skip_seq) begin
                            res_status = acpd_pkg::ST_SEQUENCE;
                        end else if (crc_mode) begin
                            if ({i_cmd.rx_byte, r_prev} != r_crc) begin
                                res_status = acpd_pkg::ST_CRC;
                            end
                        end else if ((8'h00 - r_sum) != i_cmd.rx_byte) begin
                            res_status = acpd_pkg::ST_CHECKSUM;
                        end
                    end
                end else begin
                    case (r_idx)
                        acpd_pkg::IDX_ADDRESS: n_addr = i_cmd.rx_byte;
                        acpd_pkg::IDX_LEN_LO:  n_len  = {r_len[15:8], i_cmd.rx_byte};
                        acpd_pkg::IDX_LEN_HI:  n_len  = {i_cmd.rx_byte, r_len[7:0]};
                        acpd_pkg::IDX_CONTROL: n_ctrl = i_cmd.rx_byte;
                        default: ;
                    endcase
                    if (r_idx != 16'd0) begin
                        // bytes 1 to 4 always count; later bytes stop before the trailer
                        if (r_idx <= 16'd4 || idx_wide + 17'd2 <= len_wide) begin
                            n_crc = crc_next;
                        end
                        if (r_idx <= 16'd4 || idx_wide + 17'd1 <= len_wide) begin
                            n_sum = r_sum + i_cmd.rx_byte;
                        end
                    end
                    n_prev = i_cmd.rx_byte;
                    if (r_idx != 16'hFFFF) begin
                        n_idx = r_idx + 16'd1;
                    end
                    if (r_idx >= acpd_pkg::HDR_LEN && idx_wide + top <= len_wide) begin
                        res_valid   = 1'b1;
                        res_kind    = acpd_pkg::KIND_PAYLOAD;
                        res_payload = i_cmd.rx_byte;
                    end
                end
            end
            default: ;
        endcase

        if (clear_frame) begin
            n_idx     = 16'd0;
            n_len     = 16'd0;
            n_addr    = 8'h00;
            n_ctrl    = 8'h00;
            n_mark_ok = 1'b1;
            n_crc     = acpd_pkg::CRC_SEED;
            n_sum     = 8'h00;
            n_prev    = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= 7'd0;
            r_periph      <= 1'b0;
            r_skip_seq    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                acpd_pkg::CFG_OWN_ADDRESS: r_own_address <= i_cfg_data[6:0];
                acpd_pkg::CFG_PERIPH_MODE: r_periph      <= i_cfg_data[0];
                acpd_pkg::CFG_SKIP_SEQ:    r_skip_seq    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= 16'd0;
            r_len     <= 16'd0;
            r_addr    <= 8'h00;
            r_ctrl    <= 8'h00;
            r_mark_ok <= 1'b1;
            r_crc     <= acpd_pkg::CRC_SEED;
            r_sum     <= 8'h00;
            r_prev    <= 8'h00;
            r_seq     <= acpd_pkg::SEQ_RESET;
        end else if (o_pop) begin
            r_idx     <= n_idx;
            r_len     <= n_len;
            r_addr    <= n_addr;
            r_ctrl    <= n_ctrl;
            r_mark_ok <= n_mark_ok;
            r_crc     <= n_crc;
            r_sum     <= n_sum;
            r_prev    <= n_prev;
            r_seq     <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && res_valid) begin
            r_kind    <= res_kind;
            r_payload <= res_payload;
            r_status  <= res_status;
            r_seq_out <= res_seq;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_kind;
    assign o_payload_byte = r_payload;
    assign o_frame_status = r_status;
    assign o_sequence_out = r_seq_out;
    assign o_is_last      = (r_kind == acpd_pkg::KIND_STATUS);

endmodule

// ===== rtl/core/access_control_packet_deframer.sv =====
// Packet receive deframer for an access-control serial link.
// Input channel (i_in_valid/o_in_ready): one request per transfer. A received
// byte is checked against header, length, address, sequence and crc-16 or
// checksum trailer; a header gets the next sequence number (the current one
// in peripheral mode); a link reset drops a partial frame, restarts sequence.
// Output channel (o_out_valid/i_out_ready): payload bytes as they arrive,
// one status result (o_is_last high) per frame, or a sequence number.
// Configuration channel (i_cfg_valid/o_cfg_ready, always ready): index 0 own
// address, 1 peripheral mode, 2 skip sequence check; write only while idle.
// Throughput: one request per cycle sustained while the receiver takes results.
// A request passes the command queue register and then the result register; a
// result is shown the cycle after the edge that takes its request from the
// command queue, with crc update and verdict combinational before that edge.
// When the receiver stalls the result register holds and the command queue
// fills; o_in_ready falls once QUEUE_DEPTH requests wait.
// Reset clears configuration, frame state, queue and output valid.
// depends on acpd_pkg, acpd_front, acpd_queue, acpd_back
module access_control_packet_deframer #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [acpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [acpd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_req_type,
    input  logic [7:0]                      i_rx_byte,
    input  logic                            i_frame_end,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_result_kind,
    output logic [7:0]                      o_payload_byte,
    output logic [2:0]                      o_frame_status,
    output logic [1:0]                      o_sequence_out,
    output logic                            o_is_last
);

    acpd_pkg::t_cmd push_cmd, head_cmd;
    logic           push, queue_full, head_valid, pop;

    assign o_cfg_ready = 1'b1;

    acpd_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_rx_byte    (i_rx_byte),
        .i_frame_end  (i_frame_end),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    acpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_cmd   (head_cmd)
    );

    acpd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd_valid    (head_valid),
        .i_cmd          (head_cmd),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_kind  (o_result_kind),
        .o_payload_byte (o_payload_byte),
        .o_frame_status (o_frame_status),
        .o_sequence_out (o_sequence_out),
        .o_is_last      (o_is_last)
    );

endmodule

// ===== rtl/core/acpd_checker.sv =====
// port-level checks for the deframer, attached by bind
// depends on acpd_pkg and access_control_packet_deframer
module acpd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_result_kind,
    input logic       o_is_last
);

    // a stalled result stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // is_last marks exactly the frame status results
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_last == (o_result_kind == acpd_pkg::KIND_STATUS)))
        else $error("is_last disagrees with result kind");

    // only defined result kinds leave the block
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_result_kind == acpd_pkg::KIND_PAYLOAD
                      || o_result_kind == acpd_pkg::KIND_STATUS
                      || o_result_kind == acpd_pkg::KIND_SEQUENCE))
        else $error("undefined result kind");

    // no result can appear right out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind access_control_packet_deframer acpd_checker u_acpd_checker (.*);

// ===== bench/acpd_result_checker.sv =====
// bench package and result checker for the access-control packet deframer
// watches the config, request and result channels, predicts each result, compares
// depends on acpd_pkg
`timescale 1ns / 1ps

package acpd_bench_pkg;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // bitwise crc-16, msb first
    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ data[k];
            c = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ acpd_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    // three-bit signed counter, 3 wraps to 1
    function automatic logic [2:0] seq_next(input logic [2:0] s);
        logic signed [3:0] v;
        v = $signed({s[2], s}) + 4'sd1;
        if (v > 4'sd3) begin
            v = 4'sd1;
        end
        return v[2:0];
    endfunction

endpackage

module acpd_result_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_end,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [1:0] i_result_kind,
    input  logic [7:0] i_payload_byte,
    input  logic [2:0] i_frame_status,
    input  logic [1:0] i_sequence_out,
    input  logic       i_is_last,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_results_checked
);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload;
        logic [2:0] status;
        logic [1:0] seq;
        logic       last;
    } t_deframe_result;

    t_deframe_result expected_results[$];

    // configuration copy
    logic [6:0]  own_address;
    logic        peripheral_mode;
    logic        skip_seq_check;

    // frame state
    logic [15:0] rx_pos;
    logic [15:0] length_field;
    logic [7:0]  rx_address;
    logic [7:0]  rx_control;
    logic        marks_good;
    logic [15:0] crc_acc;
    logic [7:0]  sum_acc;
    logic [7:0]  last_byte;
    logic [2:0]  link_seq;

    int fails   = 0;
    int checked = 0;

    task automatic clear_frame();
        rx_pos       = '0;
        length_field = '0;
        rx_address   = '0;
        rx_control   = '0;
        marks_good   = 1'b1;
        crc_acc      = acpd_pkg::CRC_SEED;
        sum_acc      = '0;
        last_byte    = '0;
    endtask

    task automatic apply_register(input logic [1:0] idx, input logic [7:0] data);
        case (idx)
            acpd_pkg::CFG_OWN_ADDRESS: own_address = data[6:0];
            acpd_pkg::CFG_PERIPH_MODE: peripheral_mode = data[0];
            acpd_pkg::CFG_SKIP_SEQ:    skip_seq_check = data[0];
            default: ;
        endcase
    endtask

    // status of a frame closed by byte b sitting at position pos
    task automatic judge_frame(input logic [7:0] b, input logic [15:0] pos,
                               output logic [2:0] st);
        logic        crc_mode;
        logic [15:0] min_last;
        logic [7:0]  want_sum;
        crc_mode = rx_control[acpd_pkg::CTRL_CRC_BIT];
        min_last = crc_mode ? acpd_pkg::MIN_LAST_CRC : acpd_pkg::MIN_LAST_SUM;
        want_sum = 8'h00 - sum_acc;
        if (pos < 16'd1 || !marks_good) begin
            st = acpd_pkg::ST_MARK;
        end else if (pos < min_last || pos != length_field) begin
            st = acpd_pkg::ST_LENGTH;
        end else if (!peripheral_mode && !rx_address[acpd_pkg::ADDR_REPLY_BIT]) begin
            st = acpd_pkg::ST_REPLY;
        end else if (rx_address[6:0] != own_address) begin
            st = acpd_pkg::ST_ADDRESS;
        end else begin
            // peripheral advances even when the mismatch is ignored
            if (peripheral_mode) begin
                link_seq = acpd_bench_pkg::seq_next(link_seq);
            end
            if (link_seq[1:0] != rx_control[1:0] && !skip_seq_check) begin
                st = acpd_pkg::ST_SEQUENCE;
            end else if (crc_mode) begin
                st = ({b, last_byte} != crc_acc) ? acpd_pkg::ST_CRC : acpd_pkg::ST_OK;
            end else begin
                st = (want_sum != b) ? acpd_pkg::ST_CHECKSUM : acpd_pkg::ST_OK;
            end
        end
    endtask

    task automatic deframe_request(input logic [1:0] req, input logic [7:0] b,
                                   input logic fe);
        t_deframe_result r;
        logic [15:0]     pos;
        logic [2:0]      st;
        int unsigned     pos_n;
        int unsigned     len_n;
        int unsigned     trail;
        r = '0;
        case (req)
            acpd_pkg::REQ_TX_HEADER: begin
                if (!peripheral_mode) begin
                    link_seq = acpd_bench_pkg::seq_next(link_seq);
                end
                r.kind = acpd_pkg::KIND_SEQUENCE;
                r.seq  = link_seq[1:0];
                expected_results.push_back(r);
            end
            acpd_pkg::REQ_LINK_RESET: begin
                link_seq = acpd_pkg::SEQ_RESET;
                clear_frame();
            end
            acpd_pkg::REQ_RX_BYTE: begin
                pos = rx_pos;
                if (pos == 16'd0 && b != acpd_pkg::MARK_BYTE) begin
                    marks_good = 1'b0;
                end
                if (pos == 16'd1 && b != acpd_pkg::START_BYTE) begin
                    marks_good = 1'b0;
                end
                if (fe) begin
                    judge_frame(b, pos, st);
                    r.kind   = acpd_pkg::KIND_STATUS;
                    r.status = st;
                    r.last   = 1'b1;
                    expected_results.push_back(r);
                    clear_frame();
                end else begin
                    case (pos)
                        acpd_pkg::IDX_ADDRESS: rx_address = b;
                        acpd_pkg::IDX_LEN_LO:  length_field[7:0] = b;
                        acpd_pkg::IDX_LEN_HI:  length_field[15:8] = b;
                        acpd_pkg::IDX_CONTROL: rx_control = b;
                        default: ;
                    endcase
                    pos_n = 32'(pos);
                    len_n = 32'(length_field);
                    if (pos_n >= 1) begin
                        if (pos_n <= 4 || pos_n + 2 <= len_n) begin
                            crc_acc = acpd_bench_pkg::crc16_next(crc_acc, b);
                        end
                        if (pos_n <= 4 || pos_n + 1 <= len_n) begin
                            sum_acc = sum_acc + b;
                        end
                    end
                    last_byte = b;
                    if (rx_pos != 16'hFFFF) begin
                        rx_pos = rx_pos + 16'd1;
                    end
                    if (pos >= acpd_pkg::HDR_LEN) begin
                        trail = rx_control[acpd_pkg::CTRL_CRC_BIT] ? 32'd2 : 32'd1;
                        if (pos_n + trail <= len_n) begin
                            r.kind    = acpd_pkg::KIND_PAYLOAD;
                            r.payload = b;
                            expected_results.push_back(r);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(input string fname, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_deframe_result want;
        if (!i_rst_n) begin
            own_address     = '0;
            peripheral_mode = 1'b0;
            skip_seq_check  = 1'b0;
            link_seq        = acpd_pkg::SEQ_RESET;
            clear_frame();
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, got kind %0d",
                             $time, i_result_kind);
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    compare_field("result_kind", 8'(want.kind), 8'(i_result_kind));
                    compare_field("payload_byte", want.payload, i_payload_byte);
                    compare_field("frame_status", 8'(want.status), 8'(i_frame_status));
                    compare_field("sequence_out", 8'(want.seq), 8'(i_sequence_out));
                    compare_field("is_last", 8'(want.last), 8'(i_is_last));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                apply_register(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && i_in_ready) begin
                deframe_request(i_req_type, i_rx_byte, i_frame_end);
            end
        end
        o_fail_count      <= fails;
        o_pending         <= expected_results.size();
        o_results_checked <= checked;
    end

endmodule

// ===== bench/tb_top.sv =====
// top of the access-control packet deframer bench: clock, reset, stimulus and verdict
// depends on acpd_pkg, acpd_bench_pkg and acpd_result_checker
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PHASE_ITEMS    = 50;
    localparam int NUM_PHASES     = 8;

    // frame faults injected by the frame builder
    localparam int FAULT_NONE     = 0;
    localparam int FAULT_MARK     = 1;
    localparam int FAULT_START    = 2;
    localparam int FAULT_LENGTH   = 3;
    localparam int FAULT_REPLY    = 4;
    localparam int FAULT_ADDRESS  = 5;
    localparam int FAULT_SEQUENCE = 6;
    localparam int FAULT_TRAILER  = 7;
    localparam int FAULT_CUT      = 8;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [1:0] i_req_type;
    logic [7:0] i_rx_byte;
    logic       i_frame_end;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [1:0] o_result_kind;
    logic [7:0] o_payload_byte;
    logic [2:0] o_frame_status;
    logic [1:0] o_sequence_out;
    logic       o_is_last;

    int fail_count;
    int pending_count;
    int results_checked;
    int items_sent  = 0;
    int idle_cycles = 0;

    logic       stall_on;
    logic [7:0] frame_bytes[$];
    logic [6:0] cur_address;
    logic       cur_periph;
    logic       cur_skip;
    logic [2:0] tx_seq;

    access_control_packet_deframer u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_rx_byte      (i_rx_byte),
        .i_frame_end    (i_frame_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_kind  (o_result_kind),
        .o_payload_byte (o_payload_byte),
        .o_frame_status (o_frame_status),
        .o_sequence_out (o_sequence_out),
        .o_is_last      (o_is_last)
    );

    acpd_result_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_req_type        (i_req_type),
        .i_rx_byte         (i_rx_byte),
        .i_frame_end       (i_frame_end),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_result_kind     (o_result_kind),
        .i_payload_byte    (o_payload_byte),
        .i_frame_status    (o_frame_status),
        .i_sequence_out    (o_sequence_out),
        .i_is_last         (o_is_last),
        .o_fail_count      (fail_count),
        .o_pending         (pending_count),
        .o_results_checked (results_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver side back-pressure
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            i_out_ready <= !(stall_on && $urandom_range(99) < 6);
        end
    end

    // ends the run when no channel moves a transfer for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("access_control_packet_deframer verification failed");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] req, input logic [7:0] b, input logic fe);
        while (stall_on && $urandom_range(99) < 6) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= req;
        i_rx_byte   <= b;
        i_frame_end <= fe;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for every outstanding result, then let queued no-result requests drain
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic build_frame(input int fault, input int n_pay, input logic crc_mode);
        int          len_field;
        int          cut;
        logic [7:0]  addr;
        logic [7:0]  ctrl;
        logic [7:0]  sum;
        logic [15:0] crc;
        logic [2:0]  want_seq;
        frame_bytes.delete();
        len_field = 5 + n_pay + (crc_mode ? 2 : 1);
        want_seq  = cur_periph ? acpd_bench_pkg::seq_next(tx_seq) : tx_seq;
        addr[6:0] = cur_address;
        addr[7]   = cur_periph ? 1'($urandom_range(1)) : 1'b1;
        ctrl      = 8'($urandom);
        ctrl[acpd_pkg::CTRL_CRC_BIT] = crc_mode;
        ctrl[1:0] = want_seq[1:0];
        case (fault)
            FAULT_LENGTH: begin
                if ($urandom_range(1)) begin
                    len_field = len_field + int'($urandom_range(1, 3));
                end else begin
                    len_field = len_field - int'($urandom_range(1, 3));
                end
            end
            FAULT_REPLY:    addr[7] = 1'b0;
            FAULT_ADDRESS:  addr[6:0] = addr[6:0] ^ 7'($urandom_range(1, 127));
            FAULT_SEQUENCE: ctrl[1:0] = ctrl[1:0] ^ 2'($urandom_range(1, 3));
            default: ;
        endcase
        if (fault == FAULT_MARK) begin
            frame_bytes.push_back(8'($urandom_range(0, 254)));
        end else begin
            frame_bytes.push_back(acpd_pkg::MARK_BYTE);
        end
        if (fault == FAULT_START) begin
            frame_bytes.push_back(acpd_pkg::START_BYTE ^ 8'($urandom_range(1, 255)));
        end else begin
            frame_bytes.push_back(acpd_pkg::START_BYTE);
        end
        frame_bytes.push_back(addr);
        frame_bytes.push_back(len_field[7:0]);
        frame_bytes.push_back(len_field[15:8]);
        frame_bytes.push_back(ctrl);
        repeat (n_pay) frame_bytes.push_back(8'($urandom));
        // trailer covers everything after the mark
        crc = acpd_pkg::CRC_SEED;
        sum = '0;
        for (int i = 1; i < frame_bytes.size(); i++) begin
            crc = acpd_bench_pkg::crc16_next(crc, frame_bytes[i]);
            sum = sum + frame_bytes[i];
        end
        if (crc_mode) begin
            frame_bytes.push_back(crc[7:0]);
            frame_bytes.push_back(crc[15:8]);
        end else begin
            frame_bytes.push_back(8'h00 - sum);
        end
        if (fault == FAULT_TRAILER) begin
            cut = frame_bytes.size() - 1 - int'($urandom_range(32'(crc_mode)));
            frame_bytes[cut] = frame_bytes[cut] ^ (8'h01 << $urandom_range(7));
        end
        if (fault == FAULT_CUT) begin
            cut = int'($urandom_range(0, frame_bytes.size() - 2));
            while (frame_bytes.size() > cut + 1) void'(frame_bytes.pop_back());
            // a declared length that matches but is too short for the trailer
            if (cut >= 5 && cut < (crc_mode ? 7 : 6) && $urandom_range(1)) begin
                frame_bytes[3] = cut[7:0];
                frame_bytes[4] = 8'h00;
            end
        end
        if (cur_periph && (fault == FAULT_NONE || fault == FAULT_REPLY ||
                           fault == FAULT_SEQUENCE || fault == FAULT_TRAILER)) begin
            tx_seq = acpd_bench_pkg::seq_next(tx_seq);
        end
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++) begin
            send_request(acpd_pkg::REQ_RX_BYTE, frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    initial begin : stimulus
        int         phase_start;
        int         pick;
        int         fsel;
        int         n_pay;
        int         n_noise;
        logic       ending;
        logic [7:0] data;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_req_type  = '0;
        i_rx_byte   = '0;
        i_frame_end = 1'b0;
        stall_on    = 1'b1;
        cur_address = '0;
        cur_periph  = 1'b0;
        cur_skip    = 1'b0;
        tx_seq      = acpd_pkg::SEQ_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, controller mode
        send_request(acpd_bench_pkg::REQ_UNUSED, 8'hA5, 1'b1);
        send_request(acpd_pkg::REQ_TX_HEADER, 8'h00, 1'b0);
        tx_seq = acpd_bench_pkg::seq_next(tx_seq);
        build_frame(FAULT_NONE, 0, 1'b1);
        send_frame();
        build_frame(FAULT_NONE, 1, 1'b0);
        send_frame();
        // frame that ends on its very first byte
        send_request(acpd_pkg::REQ_RX_BYTE, acpd_pkg::MARK_BYTE, 1'b1);
        send_request(acpd_pkg::REQ_LINK_RESET, 8'hFF, 1'b1);
        tx_seq = acpd_pkg::SEQ_RESET;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            case (ph)
                0: begin cur_address = 7'd127; cur_periph = 1'b1; cur_skip = 1'b0; end
                1: begin cur_address = 7'd0;   cur_periph = 1'b1; cur_skip = 1'b1; end
                2: begin cur_address = 7'd127; cur_periph = 1'b0; cur_skip = 1'b1; end
                3: begin cur_address = 7'd0;   cur_periph = 1'b0; cur_skip = 1'b0; end
                default: begin
                    cur_address = 7'($urandom);
                    cur_periph  = 1'($urandom_range(1));
                    cur_skip    = 1'($urandom_range(1));
                end
            endcase
            data = 8'($urandom);
            data[6:0] = cur_address;
            write_reg(acpd_pkg::CFG_OWN_ADDRESS, data);
            data = 8'($urandom);
            data[0] = cur_periph;
            write_reg(acpd_pkg::CFG_PERIPH_MODE, data);
            data = 8'($urandom);
            data[0] = cur_skip;
            write_reg(acpd_pkg::CFG_SKIP_SEQ, data);
            write_reg(acpd_bench_pkg::CFG_UNUSED, 8'($urandom));
            // one phase runs with no idling on either side
            stall_on <= (ph != 3);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                pick = int'($urandom_range(99));
                if (pick < 60) begin
                    fsel  = int'($urandom_range(15));
                    n_pay = ($urandom_range(9) == 0) ? int'($urandom_range(20, 60))
                                                      : int'($urandom_range(0, 6));
                    build_frame((fsel < 8) ? FAULT_NONE : fsel - 7, n_pay,
                                1'($urandom_range(1)));
                    send_frame();
                end else if (pick < 72) begin
                    send_request(acpd_pkg::REQ_TX_HEADER, 8'($urandom),
                                 1'($urandom_range(1)));
                    if (!cur_periph) begin
                        tx_seq = acpd_bench_pkg::seq_next(tx_seq);
                    end
                end else if (pick < 77) begin
                    send_request(acpd_pkg::REQ_LINK_RESET, 8'($urandom),
                                 1'($urandom_range(1)));
                    tx_seq = acpd_pkg::SEQ_RESET;
                end else if (pick < 80) begin
                    send_request(acpd_bench_pkg::REQ_UNUSED, 8'($urandom),
                                 1'($urandom_range(1)));
                end else begin
                    // line noise, sometimes left open and dropped by a link reset
                    n_noise = int'($urandom_range(1, 4));
                    ending  = ($urandom_range(3) != 0);
                    for (int k = 0; k < n_noise; k++) begin
                        send_request(acpd_pkg::REQ_RX_BYTE, 8'($urandom),
                                     ending && (k == n_noise - 1));
                    end
                    if (!ending) begin
                        send_request(acpd_pkg::REQ_LINK_RESET, 8'($urandom),
                                     1'($urandom_range(1)));
                        tx_seq = acpd_pkg::SEQ_RESET;
                    end
                end
            end
        end
        settle();

        $display("run covered %0d requests over %0d register settings, %0d results compared",
                 items_sent, NUM_PHASES + 1, results_checked);
        $display("frames with every fault kind, cut frames, headers, link resets and noise");
        if (fail_count == 0 && pending_count == 0) begin
            $display("access_control_packet_deframer verification clean");
        end else begin
            $display("access_control_packet_deframer verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/acpd_pkg.sv
rtl/core/acpd_front.sv
rtl/core/acpd_queue.sv
rtl/core/acpd_back.sv
rtl/core/access_control_packet_deframer.sv
rtl/core/acpd_checker.sv
bench/acpd_result_checker.sv
bench/tb_top.sv
